### sv/p2sca_pkg.sv
// ----------------------------------------------------------------------------
// p2sca_pkg: shared types and constants of the size-class allocator
// Field widths of the request and response items, action and status codes.
// ----------------------------------------------------------------------------
package p2sca_pkg;

   localparam int ACTION_W   = 1;
   localparam int REQ_SIZE_W = 14;
   localparam int ADDR_W     = 16;
   localparam int STATUS_W   = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED = 2'd0,
      ST_FREED     = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_TOO_LARGE = 2'd3
   } status_type;

endpackage

### sv/p2sca_ifs.sv
// ----------------------------------------------------------------------------
// p2sca channel interfaces
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface p2sca_req_if;
   logic                                valid;
   logic                                ready;
   p2sca_pkg::action_type               action;
   logic [p2sca_pkg::REQ_SIZE_W-1:0]    request_size;
   logic [p2sca_pkg::ADDR_W-1:0]        block_address;

   modport source (output valid, action, request_size, block_address, input ready);
   modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface p2sca_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [p2sca_pkg::ADDR_W-1:0]        granted_address;
   p2sca_pkg::status_type               status;

   modport source (output valid, granted_address, status, input ready);
   modport sink   (input valid, granted_address, status, output ready);
endinterface

### sv/power_of_two_size_class_allocator.sv
// ----------------------------------------------------------------------------
// power_of_two_size_class_allocator
// Power-of-two block allocator with per-order LIFO free lists over a page pool.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per allocate or free: action, request_size and,
//   for a free, block_address. rsp_chan returns exactly one item per request:
//   granted_address and status (allocated, freed, pool exhausted, too large).
//   Items are processed one at a time. The response register loads from
//   S_READ, after the registered table read (free, carve, new page, too
//   large, exhausted), or from S_LINK for an allocate that pops a free list:
//   S_LINK waits on the registered read of the link memory at the list head.
//   The per-order table read is the other memory access. The next request is
//   accepted only once the engine is back in S_IDLE.
//   The response sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls and the register is still full, the
//   engine holds its finished item (no memory writes) until the slot frees.
//   Reset clears the FSM, the page counter and the per-order row-valid bits,
//   so every order reads as empty with nothing to carve. The link memory is
//   never cleared: an entry is only read after a free has written it.
// ----------------------------------------------------------------------------
module power_of_two_size_class_allocator #(
   parameter int PAGE_ORDER = 12,
   parameter int MIN_ORDER  = 4,
   parameter int POOL_PAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   p2sca_req_if.sink   req_chan,
   p2sca_rsp_if.source rsp_chan
);

   import p2sca_pkg::*;

   localparam int NUM_ORDERS = PAGE_ORDER - MIN_ORDER + 1;
   localparam int S_W        = $clog2(NUM_ORDERS);
   localparam int CL_W       = PAGE_ORDER - MIN_ORDER;       // carve count width
   localparam int PAGE_GRAN  = 1 << (PAGE_ORDER - MIN_ORDER);
   localparam int LINK_DEPTH = POOL_PAGES * PAGE_GRAN;
   localparam int G_W        = $clog2(LINK_DEPTH);            // granule index
   localparam int PU_W       = $clog2(POOL_PAGES + 1);
   localparam int AX_W       = G_W + MIN_ORDER + ADDR_W;     // address staging

   // per-order table row
   typedef struct packed {
      logic            head_valid;
      logic [G_W-1:0]  head;
      logic [G_W-1:0]  carve_next;
      logic [CL_W-1:0] carve_left;
   } order_row_type;

   localparam int ROW_W = $bits(order_row_type);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_LINK = 3'b100
   } fsm_type;

   // size to order class index (0 = one granule)
   function automatic logic [S_W-1:0] size_class(input logic [REQ_SIZE_W-1:0] size);
      logic [S_W-1:0] cls;
      cls = S_W'(NUM_ORDERS - 1);
      for (int o = PAGE_ORDER; o >= MIN_ORDER; o--) begin
         if ((32'd1 << o) >= 32'(size)) begin
            cls = S_W'(o - MIN_ORDER);
         end
      end
      return cls;
   endfunction

   function automatic logic [ADDR_W-1:0] gran_addr(input logic [G_W-1:0] g);
      logic [AX_W-1:0] wide;
      wide = AX_W'(g) << MIN_ORDER;
      return wide[ADDR_W-1:0];
   endfunction

   fsm_type              state_ff, state_in;
   logic [PU_W-1:0]      pages_used_ff, pages_used_in;
   logic [NUM_ORDERS-1:0] row_valid_ff, row_valid_in;

   // captured item
   action_type           action_ff;
   logic                 too_large_ff;
   logic [S_W-1:0]       cls_ff;
   logic [G_W-1:0]       free_g_ff;
   logic                 free_ok_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   status_type           rsp_status_ff, rsp_status_in;

   // memory ports
   logic                 ord_we;
   logic [S_W-1:0]       ord_raddr;
   order_row_type        ord_wdata, ord_rdata, row;
   logic                 link_we;
   logic [G_W-1:0]       link_waddr, link_wdata, link_raddr, link_rdata;

   logic                 accept, out_free, finish;
   logic [31:0]          free_g32;
   logic [G_W-1:0]       step;
   logic [CL_W:0]        page_chunks;
   logic [G_W-1:0]       base;

   p2sca_ram #(.WIDTH(ROW_W), .DEPTH(NUM_ORDERS)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (cls_ff),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   p2sca_ram #(.WIDTH(G_W), .DEPTH(LINK_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.granted_address = rsp_addr_ff;
   assign rsp_chan.status          = rsp_status_ff;

   assign free_g32 = 32'(req_chan.block_address >> MIN_ORDER);

   // table address follows the request at accept, then holds the item's class
   assign ord_raddr  = (state_ff == S_IDLE) ? size_class(req_chan.request_size) : cls_ff;
   // a row never written reads as reset: empty list, nothing to carve
   assign row        = row_valid_ff[cls_ff] ? ord_rdata : '0;
   assign link_raddr = row.head;

   assign step        = G_W'(1) << cls_ff;
   assign page_chunks = (CL_W+1)'(PAGE_GRAN) >> cls_ff;
   assign base        = G_W'(pages_used_ff) << (PAGE_ORDER - MIN_ORDER);

   always_comb begin
      state_in      = state_ff;
      pages_used_in = pages_used_ff;
      row_valid_in  = row_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      ord_we        = 1'b0;
      ord_wdata     = row;
      link_we       = 1'b0;
      link_waddr    = free_g_ff;
      link_wdata    = row.head_valid ? row.head : free_g_ff;
      finish        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!too_large_ff && action_ff == ACT_ALLOC && row.head_valid) begin
               state_in = S_LINK;                 // need the link at the head
            end else if (out_free) begin
               finish        = 1'b1;
               rsp_addr_in   = '0;
               if (too_large_ff) begin
                  rsp_status_in = ST_TOO_LARGE;
               end else if (action_ff == ACT_FREE) begin
                  rsp_status_in = ST_FREED;
                  if (free_ok_ff) begin
                     link_we              = 1'b1;
                     ord_we               = 1'b1;
                     ord_wdata.head       = free_g_ff;
                     ord_wdata.head_valid = 1'b1;
                  end
               end else if (row.carve_left != '0) begin
                  rsp_status_in        = ST_ALLOCATED;
                  rsp_addr_in          = gran_addr(row.carve_next);
                  ord_we               = 1'b1;
                  ord_wdata.carve_next = row.carve_next + step;
                  ord_wdata.carve_left = row.carve_left - CL_W'(1);
               end else if (pages_used_ff < PU_W'(POOL_PAGES)) begin
                  rsp_status_in        = ST_ALLOCATED;
                  rsp_addr_in          = gran_addr(base);
                  pages_used_in        = pages_used_ff + PU_W'(1);
                  ord_we               = 1'b1;
                  ord_wdata.carve_next = base + step;
                  ord_wdata.carve_left = CL_W'(page_chunks - (CL_W+1)'(1));
               end else begin
                  rsp_status_in = ST_EXHAUSTED;
               end
            end
         end
         S_LINK: begin
            if (out_free) begin
               finish        = 1'b1;
               rsp_status_in = ST_ALLOCATED;
               rsp_addr_in   = gran_addr(row.head);
               ord_we        = 1'b1;
               // a self link marks the tail
               if (link_rdata == row.head) begin
                  ord_wdata.head_valid = 1'b0;
               end else begin
                  ord_wdata.head = link_rdata;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
      end
      if (ord_we) begin
         row_valid_in[cls_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pages_used_ff <= '0;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pages_used_ff <= pages_used_in;
         row_valid_ff  <= row_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         action_ff    <= req_chan.action;
         too_large_ff <= 32'(req_chan.request_size) > (32'd1 << PAGE_ORDER);
         cls_ff       <= size_class(req_chan.request_size);
         free_g_ff    <= free_g32[G_W-1:0];
         free_ok_ff   <= free_g32 < 32'(LINK_DEPTH);
      end
   end

endmodule

### sv/p2sca_ram.sv
// ----------------------------------------------------------------------------
// p2sca_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module p2sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/p2sca_chk.sv
// ----------------------------------------------------------------------------
// p2sca_chk: port-level checks for the size-class allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module p2sca_chk #(
   parameter int MIN_ORDER = 4
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [p2sca_pkg::ADDR_W-1:0]    rsp_addr,
   input p2sca_pkg::status_type           rsp_status
);

   import p2sca_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
      else $error("response changed while stalled");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ALLOCATED |-> rsp_addr == '0)
      else $error("nonzero address on a non-grant response");

   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ALLOCATED |-> rsp_addr[MIN_ORDER-1:0] == '0)
      else $error("granted address not granule aligned");

endmodule

bind power_of_two_size_class_allocator p2sca_chk #(.MIN_ORDER(MIN_ORDER)) u_p2sca_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_addr   (rsp_chan.granted_address),
   .rsp_status (rsp_chan.status)
);

### verif/tb_power_of_two_size_class_allocator.sv
// ----------------------------------------------------------------------------
// tb_power_of_two_size_class_allocator: self-checking bench of the allocator
// Drives allocate and free items on the request channel, keeps a shadow copy
// of the free lists, carve pointers and page counter, and checks every
// response item field by field in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_power_of_two_size_class_allocator;

   import p2sca_pkg::*;

   // Geometry, matching the default parameters of the block
   localparam int PAGE_ORDER    = 12;
   localparam int MIN_ORDER     = 4;
   localparam int POOL_PAGES    = 16;
   localparam int NUM_ORDERS    = PAGE_ORDER - MIN_ORDER + 1;
   localparam int PAGE_GRANULES = 1 << (PAGE_ORDER - MIN_ORDER);
   localparam int LINK_DEPTH    = POOL_PAGES * PAGE_GRANULES;
   localparam int PAGE_BYTES    = 1 << PAGE_ORDER;

   // Run shape
   localparam int RANDOM_ITEMS  = 1725;
   localparam int CALM_TAIL     = 150;      // last items run without idling
   localparam int LIVE_MAX      = 48;       // cap on blocks held by the bench
   localparam int HOLD_CYCLES   = 150;      // long receiver hold-off
   localparam int DRAIN_CYCLES  = 20;
   localparam int TIMEOUT_UNITS = 2_000_000;

   typedef struct {
      action_type             act;
      logic [REQ_SIZE_W-1:0]  size;
      logic [ADDR_W-1:0]      addr;
   } alloc_req_type;

   typedef struct {
      logic [ADDR_W-1:0]      addr;
      status_type             status;
   } grant_type;

   typedef struct {
      logic [ADDR_W-1:0]      addr;
      int unsigned            ord;
   } live_block_type;

   // -------------------------------------------------------------------------
   // Shadow of the pool: predicts each response at request accept time and
   // queues it; responses are checked against the oldest queued grant.
   // -------------------------------------------------------------------------
   class pool_shadow_type;
      bit          head_ok   [NUM_ORDERS];
      int unsigned head_g    [NUM_ORDERS];
      int unsigned link      [LINK_DEPTH];
      int unsigned carve_g   [NUM_ORDERS];
      int unsigned carve_cnt [NUM_ORDERS];
      int unsigned pages;
      grant_type   grant_queue[$];
      int          errors;
      int          checked;

      task report(string msg);
         errors++;
         if (errors <= 30) begin
            $display("MISMATCH rsp #%0d: %s", checked, msg);
         end
      endtask

      function int pending();
         return grant_queue.size();
      endfunction

      // Apply one accepted request to the shadow state and queue its grant.
      function grant_type note_request(alloc_req_type r);
         grant_type   g_out;
         int unsigned ord;
         int unsigned cls;
         int unsigned step;
         int unsigned g;

         g_out.addr   = '0;
         g_out.status = ST_ALLOCATED;
         if (r.size > PAGE_BYTES) begin
            // Kernel path is not modeled: too large, for free as well
            g_out.status = ST_TOO_LARGE;
         end else begin
            ord = MIN_ORDER;
            while (ord < PAGE_ORDER && (1 << ord) < r.size) ord++;
            cls  = ord - MIN_ORDER;
            step = 1 << cls;
            if (r.act == ACT_FREE) begin
               g = 32'(r.addr) >> MIN_ORDER;
               if (g < LINK_DEPTH) begin
                  // Pushing the current head again makes it link to itself
                  link[g]      = head_ok[cls] ? head_g[cls] : g;
                  head_g[cls]  = g;
                  head_ok[cls] = 1'b1;
               end
               g_out.status = ST_FREED;
            end else if (head_ok[cls]) begin
               g = head_g[cls];
               if (link[g] == g) head_ok[cls] = 1'b0;
               else head_g[cls] = link[g];
               g_out.addr = ADDR_W'(g << MIN_ORDER);
            end else if (carve_cnt[cls] != 0) begin
               g = carve_g[cls];
               carve_g[cls]   = g + step;
               carve_cnt[cls] = carve_cnt[cls] - 1;
               g_out.addr     = ADDR_W'(g << MIN_ORDER);
            end else if (pages < POOL_PAGES) begin
               g = pages * PAGE_GRANULES;
               pages++;
               carve_g[cls]   = g + step;
               carve_cnt[cls] = (1 << (PAGE_ORDER - ord)) - 1;
               g_out.addr     = ADDR_W'(g << MIN_ORDER);
            end else begin
               g_out.status = ST_EXHAUSTED;
            end
         end
         grant_queue.push_back(g_out);
         return g_out;
      endfunction

      task check_grant(logic [ADDR_W-1:0] addr, status_type status);
         grant_type want;
         checked++;
         if (grant_queue.size() == 0) begin
            report($sformatf("unexpected response addr=%h status=%s", addr, status.name()));
         end else begin
            want = grant_queue.pop_front();
            if (status !== want.status) begin
               report($sformatf("status %s, expected %s", status.name(), want.status.name()));
            end
            if (addr !== want.addr) begin
               report($sformatf("granted_address %h, expected %h", addr, want.addr));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;

   p2sca_req_if req_bus ();
   p2sca_rsp_if rsp_bus ();

   power_of_two_size_class_allocator #(
      .PAGE_ORDER (PAGE_ORDER),
      .MIN_ORDER  (MIN_ORDER),
      .POOL_PAGES (POOL_PAGES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   pool_shadow_type sb = new;
   live_block_type  live_blocks[$];  // blocks the bench currently owns
   int              idle_pct;        // chance of an idle burst, both sides
   bit              random_phase;
   logic            rsp_hold = 1'b0; // long hold-off, driven by its own process

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the handshake locks up
   initial begin
      #(TIMEOUT_UNITS);
      $display("[power_of_two_size_class_allocator] ERROR");
      $finish;
   end

   // Offer one item, with an optional idle burst first. valid is only dropped
   // when a burst follows, so back-to-back items keep it high across edges.
   task automatic send_item(input alloc_req_type r, output grant_type want);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 10);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= r.act;
      req_bus.request_size  <= r.size;
      req_bus.block_address <= r.addr;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      want = sb.note_request(r);
   endtask

   // Send and remember every block that got handed out, so later frees can
   // return it with a size from the same order.
   task automatic issue(input action_type act, input int size, input int addr);
      alloc_req_type  r;
      grant_type      want;
      live_block_type blk;
      int unsigned    ord;
      r.act  = act;
      r.size = REQ_SIZE_W'(size);
      r.addr = ADDR_W'(addr);
      send_item(r, want);
      if (act == ACT_ALLOC && want.status == ST_ALLOCATED) begin
         ord = MIN_ORDER;
         while (ord < PAGE_ORDER && (1 << ord) < size) ord++;
         blk.addr = want.addr;
         blk.ord  = ord;
         live_blocks.push_back(blk);
      end
   endtask

   // Small orders dominate so that page carving stays in play for a while;
   // the large orders burn whole pages and drive the pool to exhaustion.
   function automatic int unsigned pick_order();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 4;
      if (p < 60) return 5;
      if (p < 72) return 6;
      if (p < 82) return 7;
      if (p < 89) return 8;
      if (p < 94) return 9;
      if (p < 97) return 10;
      if (p < 99) return 11;
      return 12;
   endfunction

   // Any size that rounds up to the given order; size zero falls in the
   // smallest order.
   function automatic int size_in_order(int unsigned ord);
      if (ord == MIN_ORDER) return $urandom_range(1 << MIN_ORDER, 0);
      return $urandom_range(1 << ord, (1 << (ord - 1)) + 1);
   endfunction

   // -------------------------------------------------------------------------
   // Response side: checks each accepted item, then picks ready for the next
   // edge. One nonblocking write of ready per edge.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_grant(rsp_bus.granted_address, rsp_bus.status);
         end
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Long receiver stall early in the random part: the output register and
   // the engine fill up and the request side must back-pressure.
   initial begin : long_hold
      wait (random_phase);
      repeat ($urandom_range(20, 80)) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_seq
      live_block_type blk;
      int             idx;
      int             pick;

      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_ALLOC;
      req_bus.request_size  <= '0;
      req_bus.block_address <= '0;
      idle_pct              = 20;
      random_phase          = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Addresses in notes are what a fresh pool hands out.
      issue(ACT_ALLOC, 0,     0);         // size zero, new page 0 -> 0x0000
      issue(ACT_ALLOC, 1,     0);         // below a granule, carved -> 0x0010
      issue(ACT_ALLOC, 16,    0);         // exactly a granule -> 0x0020
      issue(ACT_ALLOC, 17,    0);         // next order, page 1 -> 0x1000
      issue(ACT_ALLOC, 4096,  0);         // whole page, page 2 -> 0x2000
      issue(ACT_ALLOC, 4097,  0);         // just over a page: too large
      issue(ACT_FREE,  16383, 16'hFFFF);  // largest size on free: too large
      issue(ACT_FREE,  8192,  16'h2000);  // top size bit alone: too large
      issue(ACT_FREE,  4096,  16'h2000);  // page back on its list
      issue(ACT_ALLOC, 3000,  0);         // pops it -> 0x2000
      issue(ACT_FREE,  1,     16'h0013);  // low address bits ignored
      issue(ACT_FREE,  16,    16'h001F);  // double free of head: self link
      issue(ACT_ALLOC, 5,     0);         // pops 0x0010, list now empty
      issue(ACT_ALLOC, 5,     0);         // back to carving -> 0x0030
      issue(ACT_FREE,  32,    16'hFFF0);  // never allocated, accepted as is
      issue(ACT_ALLOC, 32,    0);         // -> 0xFFF0
      issue(ACT_FREE,  2048,  16'h1234);  // misaligned for its order
      issue(ACT_ALLOC, 1025,  0);         // -> 0x1230
      issue(ACT_FREE,  64,    16'h0040);
      issue(ACT_FREE,  64,    16'h0080);
      issue(ACT_ALLOC, 64,    0);         // LIFO: 0x0080 first
      issue(ACT_ALLOC, 64,    0);         // then 0x0040
      issue(ACT_ALLOC, 64,    0);         // list empty, fresh page

      // Random part: mostly well-formed alloc/free traffic on blocks the bench
      // owns, plus some noise with raw fields (frees of arbitrary addresses,
      // oversize requests). Pool exhaustion shows up on its own.
      random_phase = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_TAIL) begin
            idle_pct = 0;
         end else if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 35;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            issue(action_type'($urandom_range(0, 1)), $urandom() & 16'h3FFF, $urandom() & 16'hFFFF);
         end else if (live_blocks.size() > 0 && (pick < 50 || live_blocks.size() >= LIVE_MAX)) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            issue(ACT_FREE, size_in_order(blk.ord), blk.addr | $urandom_range(0, 15));
         end else begin
            issue(ACT_ALLOC, size_in_order(pick_order()), $urandom() & 16'hFFFF);
         end
      end
      req_bus.valid <= 1'b0;

      // Drain, then a few idle cycles to catch any stray response
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[power_of_two_size_class_allocator] OK");
      end else begin
         $display("[power_of_two_size_class_allocator] ERROR");
      end
      $finish;
   end

endmodule
